[design/utf8sd_pkg.sv]
// Package for the UTF-8 stream decoder: status codes, the lead byte length
// table and the structs passed between the decoder modules. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package utf8sd_pkg;

    // Width of the saturating character counter.
    localparam int INDEX_WIDTH = 20;
    // Width of the character index as it leaves the block.
    localparam int INDEX_OUT_WIDTH = 20;
    localparam int CP_WIDTH = 31;

    localparam logic [INDEX_WIDTH-1:0] COUNT_MAX = '1;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MALFORMED = 2'd1;
    localparam logic [1:0] ST_TRUNCATED = 2'd2;
    localparam logic [1:0] ST_SURROGATE = 2'd3;

    // Sequence length for the lead bytes 0xC0 to 0xFF, indexed by the low six bits.
    localparam logic [2:0] LEAD_LEN [64] = '{
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6, 3'd6, 3'd6
    };

    // Decoder state carried from one byte to the next.
    typedef struct packed {
        logic [2:0]             bytes_remaining;
        logic [CP_WIDTH-1:0]    accumulator;
        logic [INDEX_WIDTH-1:0] char_count;
    } dec_state_t;

    // One result word.
    typedef struct packed {
        logic [CP_WIDTH-1:0]        code_point;
        logic [1:0]                 status;
        logic [INDEX_OUT_WIDTH-1:0] char_index;
        logic                       string_done;
    } dec_result_t;

endpackage

`default_nettype wire

[design/utf8sd_in_stage.sv]
// Input register of the UTF-8 stream decoder: holds one byte and its end flag.
// Uses nothing from utf8sd_pkg; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_in_stage (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,     // [7:0] in_byte
    input  wire logic       s_tlast,     // end_of_string
    input  wire logic       take,        // the held byte is consumed this cycle
    output logic            held_valid,
    output logic [7:0]      held_byte,
    output logic            held_eos
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       eos_reg;

    assign s_tready   = !valid_reg || take;
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            byte_reg <= s_tdata;
            eos_reg  <= s_tlast;
        end
    end

    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;
    assign held_eos   = eos_reg;

endmodule

`default_nettype wire

[design/utf8sd_decode.sv]
// Combinational decode step of the UTF-8 stream decoder: next state and result.
// Depends on utf8sd_pkg for the state and result structs, codes and length table.
`timescale 1ns / 1ps
`default_nettype none

module utf8sd_decode (
    input  wire logic [7:0]             in_byte,
    input  wire logic                   eos,
    input  wire utf8sd_pkg::dec_state_t cur,
    output utf8sd_pkg::dec_state_t      nxt,
    output logic                        emit,
    output utf8sd_pkg::dec_result_t     result
);

    always_comb
    begin
        logic [2:0]                      len;
        logic [4:0]                      lead_mask;
        logic [utf8sd_pkg::CP_WIDTH-1:0] acc_shift;
        logic [2:0]                      rem_dec;
        logic [utf8sd_pkg::CP_WIDTH-1:0] cp;
        logic [1:0]                      st;

        len       = utf8sd_pkg::LEAD_LEN[in_byte[5:0]];
        lead_mask = 5'h1F >> (len - 3'd2);
        acc_shift = {cur.accumulator[utf8sd_pkg::CP_WIDTH-7:0], in_byte[5:0]};
        rem_dec   = cur.bytes_remaining - 3'd1;
        cp        = '0;
        st        = utf8sd_pkg::ST_OK;
        emit      = 1'b0;
        nxt       = cur;

        if (cur.bytes_remaining == 3'd0)
        begin
            if (!in_byte[7])
            begin
                emit = 1'b1;
                cp   = utf8sd_pkg::CP_WIDTH'(in_byte);
            end
            else if (in_byte inside {[8'hC0:8'hFD]})
            begin
                if (eos)
                begin
                    emit = 1'b1;
                    st   = utf8sd_pkg::ST_TRUNCATED;
                end
                else
                begin
                    nxt.accumulator     = utf8sd_pkg::CP_WIDTH'(in_byte[4:0] & lead_mask);
                    nxt.bytes_remaining = len - 3'd1;
                end
            end
            else
            begin
                emit = 1'b1;
                st   = utf8sd_pkg::ST_MALFORMED;
            end
        end
        else if (eos && (cur.bytes_remaining > 3'd1))
        begin
            emit = 1'b1;
            st   = utf8sd_pkg::ST_TRUNCATED;
        end
        else if (in_byte[7:6] != 2'b10)
        begin
            emit = 1'b1;
            st   = utf8sd_pkg::ST_MALFORMED;
        end
        else if (rem_dec != 3'd0)
        begin
            nxt.accumulator     = acc_shift;
            nxt.bytes_remaining = rem_dec;
        end
        else
        begin
            emit                = 1'b1;
            nxt.accumulator     = '0;
            nxt.bytes_remaining = 3'd0;
            if (acc_shift inside {[31'h0000D800:31'h0000DFFF]})
            begin
                st = utf8sd_pkg::ST_SURROGATE;
            end
            else
            begin
                cp = acc_shift;
            end
        end

        // Bookkeeping shared by every result.
        if (emit)
        begin
            if ((st == utf8sd_pkg::ST_OK) && (cur.char_count != utf8sd_pkg::COUNT_MAX))
            begin
                nxt.char_count = cur.char_count + 1'b1;
            end
            if ((st != utf8sd_pkg::ST_OK) || eos)
            begin
                nxt.bytes_remaining = 3'd0;
                nxt.accumulator     = '0;
            end
            if (eos)
            begin
                nxt.char_count = '0;
            end
        end

        result.code_point  = cp;
        result.status      = st;
        result.char_index  = utf8sd_pkg::INDEX_OUT_WIDTH'(cur.char_count);
        result.string_done = eos;
    end

endmodule

`default_nettype wire

[design/utf8_stream_decoder_top.sv]
// Top level of the UTF-8 stream decoder: input register, decode step, state
// and result register. Depends on utf8sd_pkg, utf8sd_in_stage and utf8sd_decode.
`timescale 1ns / 1ps
`default_nettype none

// The decoder takes one byte of a UTF-8 string per word on the slave side, with
// tlast marking the last byte of the string, and gives one result word on the
// master side for every completed character, every error and every byte that
// ends a string. Lead bytes 0xC0 to 0xFD start sequences of two to six bytes;
// overlong forms and values above 0x10FFFF are passed as they decode, while
// values 0xD800 to 0xDFFF are reported as surrogates. On an error the offending
// byte is dropped and the decoder returns to idle. The result carries the code
// point (zero unless the status is ok), the status in tuser, the index of the
// character within its string (the count of good characters so far, saturating)
// and tlast when the byte that caused it ended the string; the count starts over
// after every such byte. The block sustains one byte per clock cycle while results
// are taken: each byte sits in an input register while the combinational decode
// step updates the state and loads the result register, so a result is valid
// once its byte has passed through the input register and the result register.
// A result that is not taken holds the decode step, and with it the input
// register, until m_tready is high.
module utf8_stream_decoder_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
    input  wire logic        s_tlast,    // end_of_string
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,    // [30:0] code_point, [50:31] char_index, rest zero
    output logic [1:0]       m_tuser,    // [1:0] status
    output logic             m_tlast     // string_done
);

    logic                    held_valid;
    logic [7:0]              held_byte;
    logic                    held_eos;
    logic                    process;
    logic                    emit;
    utf8sd_pkg::dec_state_t  state_reg;
    utf8sd_pkg::dec_state_t  state_next;
    utf8sd_pkg::dec_result_t dec_result;
    utf8sd_pkg::dec_result_t result_reg;
    logic                    out_valid_reg;
    logic                    out_valid_next;

    // The held byte is decoded whenever the result register is free or being
    // emptied, so that a byte producing a result never overwrites a pending one.
    assign process = held_valid && (!out_valid_reg || m_tready);

    utf8sd_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (process),
        .held_valid (held_valid),
        .held_byte  (held_byte),
        .held_eos   (held_eos)
    );

    utf8sd_decode u_decode (
        .in_byte (held_byte),
        .eos     (held_eos),
        .cur     (state_reg),
        .nxt     (state_next),
        .emit    (emit),
        .result  (dec_result)
    );

    // Decoder state: sequence progress, partial code point and character count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (process)
        begin
            state_reg <= state_next;
        end
    end

    // Result register valid flag.
    always_comb
    begin
        if (process && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // The result payload needs no reset; it is qualified by the valid flag.
    always_ff @(posedge clk)
    begin
        if (process && emit)
        begin
            result_reg <= dec_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result_reg.char_index, result_reg.code_point};
    assign m_tuser  = result_reg.status;
    assign m_tlast  = result_reg.string_done;

    // No more than five continuation bytes are ever outstanding.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.bytes_remaining <= 3'd5)
    else $error("bytes_remaining out of range");

    // When no sequence is in progress the partial code point is cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg.bytes_remaining == 3'd0) |-> (state_reg.accumulator == '0))
    else $error("accumulator not cleared while idle");

    // Error results never carry a code point.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != utf8sd_pkg::ST_OK)) |-> (m_tdata[30:0] == '0))
    else $error("nonzero code point on an error result");

    // A byte that ends a string leaves the decoder idle with the count cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        (process && held_eos) |=>
            ((state_reg.char_count == '0) && (state_reg.bytes_remaining == 3'd0)))
    else $error("state not cleared after end of string");

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for utf8_stream_decoder_top: directed and random byte strings
// with random idling on both sides. Depends on utf8sd_pkg and the decoder RTL.
`timescale 1ns / 1ps

module tb;

    import utf8sd_pkg::*;

    // Stop adding random strings once this many bytes are queued in total.
    localparam int unsigned STIM_BYTES  = 1680;
    // Sent byte count at which the receiver starts its long hold-off.
    localparam int unsigned HOLD_AT     = 600;
    localparam int unsigned HOLD_CYCLES = 300;
    // Queue size past which one more drain pause is placed.
    localparam int unsigned DRAIN_AT    = 1150;
    localparam int unsigned CYCLE_LIMIT = 200000;

    // One byte waiting to be offered, with its idle gap before it goes out.
    typedef struct {
        logic [7:0]  data;
        logic        last;
        int unsigned gap;
        bit          drain;
    } byte_item_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    byte_item_t  pending_bytes[$];
    dec_result_t expected_results[$];
    logic [7:0]  string_bytes[$];

    // Decoder state as the testbench tracks it.
    logic [2:0]             cont_left  = '0;
    logic [CP_WIDTH-1:0]    partial_cp = '0;
    logic [INDEX_WIDTH-1:0] good_chars = '0;

    int unsigned cycle_count    = 0;
    int unsigned mismatch_count = 0;
    int unsigned bytes_sent     = 0;
    int unsigned hold_left      = 0;
    bit          hold_done      = 1'b0;

    byte_item_t  next_word;
    dec_result_t predicted;
    int unsigned idle_cycles;
    dec_result_t observed;
    dec_result_t oldest;
    int unsigned ready_wait;

    utf8_stream_decoder_top i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Decodes one accepted byte into the tracked state. Returns 1 when the byte
    // produces a result word, which is then placed in res.
    function automatic bit decode_byte(input logic [7:0] b, input logic eos,
                                       output dec_result_t res);
        logic [2:0]          seq_len;
        logic [CP_WIDTH-1:0] cp;
        logic [1:0]          st;
        res = '0;
        cp  = '0;
        if (cont_left == 3'd0)
        begin
            if (b < 8'h80)
            begin
                st = ST_OK;
                cp = CP_WIDTH'(b);
            end
            else if (b >= 8'hC0 && b <= 8'hFD)
            begin
                if (eos)
                begin
                    st = ST_TRUNCATED;
                end
                else
                begin
                    // Sequence length follows from the count of leading ones.
                    if (b < 8'hE0)
                        seq_len = 3'd2;
                    else if (b < 8'hF0)
                        seq_len = 3'd3;
                    else if (b < 8'hF8)
                        seq_len = 3'd4;
                    else if (b < 8'hFC)
                        seq_len = 3'd5;
                    else
                        seq_len = 3'd6;
                    partial_cp = CP_WIDTH'(b & (8'h1F >> (seq_len - 3'd2)));
                    cont_left  = seq_len - 3'd1;
                    return 1'b0;
                end
            end
            else
            begin
                st = ST_MALFORMED;
            end
        end
        else if (eos && cont_left > 3'd1)
        begin
            // A string that ends early is truncated unless this was the final byte due.
            st = ST_TRUNCATED;
        end
        else if (b[7:6] != 2'b10)
        begin
            st = ST_MALFORMED;
        end
        else
        begin
            partial_cp = {partial_cp[CP_WIDTH-7:0], b[5:0]};
            cont_left  = cont_left - 3'd1;
            if (cont_left != 3'd0)
                return 1'b0;
            cp         = partial_cp;
            partial_cp = '0;
            if (cp >= 31'hD800 && cp <= 31'hDFFF)
                st = ST_SURROGATE;
            else
                st = ST_OK;
        end

        res.code_point  = (st == ST_OK) ? cp : '0;
        res.status      = st;
        res.char_index  = INDEX_OUT_WIDTH'(good_chars);
        res.string_done = eos;
        if (st == ST_OK && good_chars != COUNT_MAX)
            good_chars = good_chars + 1'b1;
        if (st != ST_OK || eos)
        begin
            cont_left  = '0;
            partial_cp = '0;
        end
        if (eos)
            good_chars = '0;
        return 1'b1;
    endfunction

    task automatic add_byte(input logic [7:0] b, input logic last, input bit fast,
                            input bit drain);
        byte_item_t item;
        item.data  = b;
        item.last  = last;
        item.gap   = fast ? 0 : $urandom_range(0, 4);
        item.drain = drain;
        pending_bytes.push_back(item);
    endtask

    // Appends a lead byte for a sequence of seq_len bytes and n_cont continuation
    // bytes, all with random payload bits.
    task automatic add_sequence(input int unsigned seq_len, input int unsigned n_cont);
        logic [7:0] lead;
        lead = ~(8'hFF >> seq_len) | (8'($urandom) & (8'hFF >> (seq_len + 1)));
        string_bytes.push_back(lead);
        repeat (n_cont)
            string_bytes.push_back({2'b10, 6'($urandom)});
    endtask

    task automatic build_stimulus();
        int unsigned n_chars;
        int unsigned pick;
        int unsigned seq_len;
        bit          fast;
        bit          drain_next;
        bit          late_drain_done;

        // Directed part: ASCII extremes, the largest two-byte and six-byte values and
        // 0x10FFFF, a surrogate, bad lead bytes, a byte that breaks a sequence, and
        // strings that end inside a sequence or on the last byte due.
        add_byte(8'h00, 1'b0, 1'b0, 1'b0);
        add_byte(8'h7F, 1'b1, 1'b0, 1'b0);
        add_byte(8'hDF, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0, 1'b0);
        add_byte(8'hED, 1'b0, 1'b0, 1'b0);
        add_byte(8'hA0, 1'b0, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0, 1'b0);
        add_byte(8'hFD, 1'b0, 1'b1, 1'b0);
        repeat (4)
            add_byte(8'hBF, 1'b0, 1'b1, 1'b0);
        add_byte(8'hBF, 1'b1, 1'b1, 1'b0);
        add_byte(8'hFE, 1'b0, 1'b0, 1'b0);
        add_byte(8'h80, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0, 1'b0);
        add_byte(8'hFF, 1'b0, 1'b0, 1'b0);
        add_byte(8'hF0, 1'b0, 1'b0, 1'b0);
        add_byte(8'h41, 1'b0, 1'b0, 1'b0);
        add_byte(8'hC0, 1'b1, 1'b0, 1'b0);
        add_byte(8'hE0, 1'b0, 1'b0, 1'b0);
        add_byte(8'hA0, 1'b1, 1'b0, 1'b0);
        add_byte(8'hC3, 1'b0, 1'b0, 1'b0);
        add_byte(8'h41, 1'b1, 1'b0, 1'b0);
        add_byte(8'hF4, 1'b0, 1'b0, 1'b0);
        add_byte(8'h8F, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b0, 1'b0, 1'b0);
        add_byte(8'hBF, 1'b1, 1'b0, 1'b0);

        // Random strings: mostly well-formed characters of every length, mixed
        // with surrogates, stray bytes and sequences cut short.
        drain_next      = 1'b1;
        late_drain_done = 1'b0;
        while (pending_bytes.size() < STIM_BYTES)
        begin
            n_chars = $urandom_range(1, 12);
            fast    = ($urandom_range(0, 3) == 0);
            string_bytes.delete();
            repeat (n_chars)
            begin
                pick    = $urandom_range(0, 99);
                seq_len = $urandom_range(2, 6);
                if (pick < 25)
                    string_bytes.push_back({1'b0, 7'($urandom)});
                else if (pick < 40)
                    add_sequence(2, 1);
                else if (pick < 55)
                    add_sequence(3, 2);
                else if (pick < 65)
                    add_sequence(4, 3);
                else if (pick < 70)
                    add_sequence(5, 4);
                else if (pick < 75)
                    add_sequence(6, 5);
                else if (pick < 80)
                begin
                    string_bytes.push_back(8'hED);
                    string_bytes.push_back({3'b101, 5'($urandom)});
                    string_bytes.push_back({2'b10, 6'($urandom)});
                end
                else if (pick < 90)
                    string_bytes.push_back(8'($urandom));
                else
                    add_sequence(seq_len, $urandom_range(0, seq_len - 2));
            end
            // Now and then the string stops inside a sequence.
            if ($urandom_range(0, 9) == 0)
            begin
                seq_len = $urandom_range(2, 6);
                add_sequence(seq_len, $urandom_range(0, seq_len - 2));
            end
            if (!late_drain_done && pending_bytes.size() > DRAIN_AT)
            begin
                drain_next      = 1'b1;
                late_drain_done = 1'b1;
            end
            for (int i = 0; i < string_bytes.size(); i++)
            begin
                add_byte(string_bytes[i], i == string_bytes.size() - 1, fast, drain_next);
                drain_next = 1'b0;
            end
        end
    endtask

    // Driver: offers queued bytes after their gaps and predicts the result of
    // each byte the moment the decoder takes it. A word marked for draining is
    // held back until every expected result has come out.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid    <= 1'b0;
            s_tdata     <= 8'h00;
            s_tlast     <= 1'b0;
            bytes_sent  <= 0;
            idle_cycles = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                if (decode_byte(s_tdata, s_tlast, predicted))
                    expected_results.push_back(predicted);
                bytes_sent <= bytes_sent + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_bytes.size() != 0 && idle_cycles >= pending_bytes[0].gap &&
                    (!pending_bytes[0].drain || expected_results.size() == 0))
                begin
                    next_word   = pending_bytes.pop_front();
                    s_tvalid    <= 1'b1;
                    s_tdata     <= next_word.data;
                    s_tlast     <= next_word.last;
                    idle_cycles = 0;
                end
                else
                begin
                    s_tvalid    <= 1'b0;
                    idle_cycles = idle_cycles + 1;
                end
            end
        end
    end

    // Long receiver hold-off, started once partway through the random part so
    // that the decoder backs up and stalls its input.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && bytes_sent >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Monitor: checks each result word against the oldest prediction and draws
    // a random stall before the next one. For a quarter of the time it never
    // stalls, so back-to-back results are seen as well.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            ready_wait = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                observed.code_point  = m_tdata[CP_WIDTH-1:0];
                observed.status      = m_tuser;
                observed.char_index  = m_tdata[CP_WIDTH +: INDEX_OUT_WIDTH];
                observed.string_done = m_tlast;
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected result cp=%h st=%0d idx=%0d done=%b",
                                 $realtime, observed.code_point, observed.status,
                                 observed.char_index, observed.string_done);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    if (observed !== oldest || m_tdata[55:CP_WIDTH+INDEX_OUT_WIDTH] !== '0)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: mismatch expected cp=%h st=%0d idx=%0d done=%b, %s",
                                     $realtime, oldest.code_point, oldest.status,
                                     oldest.char_index, oldest.string_done,
                                     $sformatf("got cp=%h st=%0d idx=%0d done=%b data=%h",
                                               observed.code_point, observed.status,
                                               observed.char_index, observed.string_done,
                                               m_tdata));
                    end
                end
                ready_wait = (cycle_count[7:6] == 2'b00) ? 0 : $urandom_range(0, 4);
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
            end
            else if (ready_wait != 0)
            begin
                m_tready   <= 1'b0;
                ready_wait = ready_wait - 1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Cycle counter with a generous run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        build_stimulus();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every byte is taken and every predicted result has come,
        // sampling between edges.
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0);

        // Then catch any stray result that comes after the last one due.
        repeat (8) @(posedge clk);
        #1;
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[sim.f]
design/utf8sd_pkg.sv
design/utf8sd_in_stage.sv
design/utf8sd_decode.sv
design/utf8_stream_decoder_top.sv
tb/sv/tb.sv
